### hdl/pvc_pkg.sv
// shared constants, register codes and arctangent table for the polar velocity command block
package pvc_pkg;

  localparam int unsigned IN_W         = 16;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned GAIN_W       = 12;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ATAN_ENTRIES = 24;
  // angle accumulator, q.30 radians with headroom for +-pi plus the atan sum
  localparam int unsigned ZW           = 34;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF     = 8;

  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 12'd128;   // 0.5 in q4.8
  localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 12'd1024;  // 4.0 in q4.8

  localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
  // 1/K of the cordic, q0.32
  localparam logic [31:0]          INV_GAIN_Q32 = 32'h9B74EDA8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINEAR_GAIN  = 2'd0,
    REG_ANGULAR_GAIN = 2'd1
  } cfg_reg_e;

  // atan(2^-i) in q.30, truncated
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### hdl/pvc_if.sv
// handshake channels of the polar velocity command block: position, command, register write
interface pvc_pos_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvc_pkg::IN_W-1:0]     rel_x;
  logic signed [pvc_pkg::IN_W-1:0]     rel_y;

  modport source (output valid, rel_x, rel_y, input ready);
  modport sink   (input valid, rel_x, rel_y, output ready);
endinterface

interface pvc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic        [pvc_pkg::OUT_W-1:0]    forward_speed;
  logic signed [pvc_pkg::OUT_W-1:0]    turn_rate;
  logic                                saturated;

  modport source (output valid, forward_speed, turn_rate, saturated, input ready);
  modport sink   (input valid, forward_speed, turn_rate, saturated, output ready);
endinterface

interface pvc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pvc_pkg::CFG_IDX_W-1:0]       index;
  logic [pvc_pkg::GAIN_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/polar_velocity_command_top.sv
// polar velocity command: cordic vectoring pipeline from target offset to speed and turn rate
//
// takes a target offset (rel_x, rel_y, signed q8.8 metres) and returns
// forward_speed = linear_gain * sqrt(x^2 + y^2) (unsigned q8.8) and
// turn_rate = angular_gain * atan2(y, x) (signed q8.8 rad/s), both rounded
// and clipped, with saturated set when either one was clipped. atan2(0, 0)
// gives 0. the block accepts one item every cycle while it is not stalled;
// an accepted item loads the prep stage and then passes through NS
// micro-rotation stages, NS being CORDIC_STAGES capped at the 24-entry
// arctangent table, then a multiply stage, a rounding stage, a second
// multiply stage and the output register. a one-entry skid buffer
// behind the output register lets the pipeline keep taking items while a
// finished result waits; the pipeline stalls only once the skid entry is
// occupied. gains are written through the register port (index 0
// linear_gain, 1 angular_gain, q4.8, other indexes ignored), which is
// always ready; write them only while no item is in flight.
// reset gains are 0.5 and 4.0. there is no memory and no clearing pass.
module polar_velocity_command_top #(
  parameter int unsigned CORDIC_STAGES = pvc_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned FRAC_BITS     = pvc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  pvc_pos_if.sink        pos_i,
  pvc_cfg_if.sink        cfg_i,
  pvc_cmd_if.source      cmd_o
);

  // stages beyond the arctangent table are not performed
  localparam int unsigned NS  = (CORDIC_STAGES < pvc_pkg::ATAN_ENTRIES) ?
                                CORDIC_STAGES : pvc_pkg::ATAN_ENTRIES;
  localparam int unsigned ZW  = pvc_pkg::ZW;
  // x/y datapath: q8.(8+FRAC_BITS) plus room for cordic growth and sign
  localparam int unsigned XW  = pvc_pkg::IN_W + FRAC_BITS + 4;
  localparam int unsigned PXW = XW - 1 + 32;                  // |x| * 1/K
  localparam int unsigned PZW = ZW + pvc_pkg::GAIN_W + 1;     // angle * gain
  localparam int unsigned TW  = PZW - 30;                     // turn before clip
  localparam int unsigned LW  = XW + pvc_pkg::GAIN_W;         // mag * gain
  localparam int unsigned SW  = LW + 1 - (FRAC_BITS + 8);     // speed before clip
  localparam int unsigned OW  = pvc_pkg::OUT_W;

  localparam logic [PXW:0]          HALF_X = (PXW+1)'(1) << 31;
  localparam logic signed [PZW-1:0] HALF_Z = PZW'(1) << 29;
  localparam logic [LW:0]           HALF_S = (LW+1)'(1) << (FRAC_BITS + 7);
  localparam logic signed [TW-1:0]  T_MAX  = TW'(32767);
  localparam logic signed [TW-1:0]  T_MIN  = TW'(-32768);
  localparam logic [SW-1:0]         S_MAX  = SW'(65535);

  typedef struct packed {
    logic [OW-1:0]        forward_speed;
    logic signed [OW-1:0] turn_rate;
    logic                 saturated;
  } cmd_t;

  // ---------------------------------------------------------------------------
  // gain registers
  // ---------------------------------------------------------------------------
  logic [pvc_pkg::GAIN_W-1:0] lin_gain_q, ang_gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= pvc_pkg::LINEAR_GAIN_RST;
      ang_gain_q <= pvc_pkg::ANGULAR_GAIN_RST;
    end else if (cfg_i.valid) begin
      unique case (pvc_pkg::cfg_reg_e'(cfg_i.index))
        pvc_pkg::REG_LINEAR_GAIN:  lin_gain_q <= cfg_i.data;
        pvc_pkg::REG_ANGULAR_GAIN: ang_gain_q <= cfg_i.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: the whole pipeline moves unless the skid entry is full
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_v_q, skid_v_d;
  logic out_v_q, out_v_d;

  assign adv         = !skid_v_q;
  assign pos_i.ready = adv;

  // ---------------------------------------------------------------------------
  // prep stage and cordic micro-rotations
  // stage 0 holds the prepared vector, stage k+1 the result of rotation k
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] x_q [0:NS];
  logic signed [XW-1:0] y_q [0:NS];
  logic signed [ZW-1:0] z_q [0:NS];
  logic signed [XW-1:0] x_d [0:NS];
  logic signed [XW-1:0] y_d [0:NS];
  logic signed [ZW-1:0] z_d [0:NS];
  logic [NS:0]          zero_q;
  logic [NS:0]          zero_d;
  logic [NS:0]          cv_q;

  always_comb begin
    logic signed [XW-1:0] xe, ye, xs, ys;
    logic signed [ZW-1:0] at;
    // widen by the guard fraction bits
    xe = XW'(pos_i.rel_x) <<< FRAC_BITS;
    ye = XW'(pos_i.rel_y) <<< FRAC_BITS;
    zero_d[0] = (pos_i.rel_x == '0) && (pos_i.rel_y == '0);
    // left half plane: flip the vector and start the angle at +-pi
    if (xe[XW-1]) begin
      x_d[0] = -xe;
      y_d[0] = -ye;
      z_d[0] = ye[XW-1] ? -pvc_pkg::PI_Q30 : pvc_pkg::PI_Q30;
    end else begin
      x_d[0] = xe;
      y_d[0] = ye;
      z_d[0] = '0;
    end
    // one rotation per stage, driven toward y = 0
    for (int i = 0; i < NS; i++) begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      at = {{(ZW-32){1'b0}}, pvc_pkg::atan_q30(i)};
      zero_d[i+1] = zero_q[i];
      if (!y_q[i][XW-1]) begin
        x_d[i+1] = x_q[i] + ys;
        y_d[i+1] = y_q[i] - xs;
        z_d[i+1] = z_q[i] + at;
      end else begin
        x_d[i+1] = x_q[i] - ys;
        y_d[i+1] = y_q[i] + xs;
        z_d[i+1] = z_q[i] - at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pos_i.valid) begin
        x_q[0]    <= x_d[0];
        y_q[0]    <= y_d[0];
        z_q[0]    <= z_d[0];
        zero_q[0] <= zero_d[0];
      end
      for (int k = 1; k <= NS; k++) begin
        if (cv_q[k-1]) begin
          x_q[k]    <= x_d[k];
          y_q[k]    <= y_d[k];
          z_q[k]    <= z_d[k];
          zero_q[k] <= zero_d[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // m1: gain removal on the magnitude, bearing times angular gain
  // ---------------------------------------------------------------------------
  logic                  m1_v_q, m2_v_q, m3_v_q;
  logic [XW-2:0]         xc;
  logic [PXW-1:0]        m1_px_d, m1_px_q;
  logic signed [PZW-1:0] m1_pz_d, m1_pz_q;
  logic                  m1_zero_q;

  assign xc      = x_q[NS][XW-1] ? '0 : x_q[NS][XW-2:0];
  assign m1_px_d = xc * pvc_pkg::INV_GAIN_Q32;
  assign m1_pz_d = z_q[NS] * $signed({1'b0, ang_gain_q});

  always_ff @(posedge clk_i) begin
    if (adv && cv_q[NS]) begin
      m1_px_q   <= m1_px_d;
      m1_pz_q   <= m1_pz_d;
      m1_zero_q <= zero_q[NS];
    end
  end

  // ---------------------------------------------------------------------------
  // m2: round magnitude, round and clip turn rate
  // ---------------------------------------------------------------------------
  logic [PXW:0]          mag_sum;
  logic [XW-1:0]         m2_mag_d, m2_mag_q;
  logic signed [PZW-1:0] tsum;
  logic signed [TW-1:0]  tq;
  logic signed [OW-1:0]  m2_turn_d, m2_turn_q;
  logic                  m2_tsat_d, m2_tsat_q;

  assign mag_sum  = {1'b0, m1_px_q} + HALF_X;
  assign m2_mag_d = mag_sum[PXW:32];
  assign tsum     = m1_pz_q + HALF_Z;
  assign tq       = tsum[PZW-1:30];  // floor of the shift by 30

  always_comb begin
    m2_turn_d = tq[OW-1:0];
    m2_tsat_d = 1'b0;
    if (m1_zero_q) begin
      m2_turn_d = '0;
    end else if (tq > T_MAX) begin
      m2_turn_d = T_MAX[OW-1:0];
      m2_tsat_d = 1'b1;
    end else if (tq < T_MIN) begin
      m2_turn_d = T_MIN[OW-1:0];
      m2_tsat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && m1_v_q) begin
      m2_mag_q  <= m2_mag_d;
      m2_turn_q <= m2_turn_d;
      m2_tsat_q <= m2_tsat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // m3: magnitude times linear gain
  // ---------------------------------------------------------------------------
  logic [LW-1:0]        m3_lp_d, m3_lp_q;
  logic signed [OW-1:0] m3_turn_q;
  logic                 m3_tsat_q;

  assign m3_lp_d = m2_mag_q * lin_gain_q;

  always_ff @(posedge clk_i) begin
    if (adv && m2_v_q) begin
      m3_lp_q   <= m3_lp_d;
      m3_turn_q <= m2_turn_q;
      m3_tsat_q <= m2_tsat_q;
    end
  end

  // ---------------------------------------------------------------------------
  // final rounding and clip of the speed
  // ---------------------------------------------------------------------------
  logic [LW:0]   sp_sum;
  logic [SW-1:0] sp;
  logic          ssat;
  cmd_t          res_d;

  assign sp_sum = {1'b0, m3_lp_q} + HALF_S;
  assign sp     = sp_sum[LW:FRAC_BITS+8];
  assign ssat   = sp > S_MAX;

  always_comb begin
    res_d.forward_speed = ssat ? S_MAX[OW-1:0] : sp[OW-1:0];
    res_d.turn_rate     = m3_turn_q;
    res_d.saturated     = ssat || m3_tsat_q;
  end

  // ---------------------------------------------------------------------------
  // valid bits of the pipeline
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q   <= '0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (adv) begin
      cv_q   <= {cv_q[NS-1:0], pos_i.valid};
      m1_v_q <= cv_q[NS];
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with skid entry
  // ---------------------------------------------------------------------------
  logic emerge, load_out;
  cmd_t out_q, skid_q;

  assign emerge   = adv && m3_v_q;
  assign load_out = !out_v_q || cmd_o.ready;

  always_comb begin
    out_v_d  = load_out ? (skid_v_q || emerge) : out_v_q;
    skid_v_d = skid_v_q ? !load_out : (emerge && !load_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end
    if (!skid_v_q && emerge && !load_out) begin
      skid_q <= res_d;
    end
  end

  assign cmd_o.valid         = out_v_q;
  assign cmd_o.forward_speed = out_q.forward_speed;
  assign cmd_o.turn_rate     = out_q.turn_rate;
  assign cmd_o.saturated     = out_q.saturated;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // the skid entry is only used behind a held output item
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid with empty output register");

  // skid fills only when the output item was not taken
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !cmd_o.ready))
    else $error("skid entry filled while output was free");

  // origin gives a zero, unclipped turn rate
  a_origin_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && m1_v_q && m1_zero_q) |=> (m2_turn_q == '0) && !m2_tsat_q)
    else $error("origin item produced a nonzero turn rate");

  // a saturated item with unclipped speed must have a clipped turn rate
  a_sat_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.saturated && (out_q.forward_speed != S_MAX[OW-1:0])) |->
      ((out_q.turn_rate == T_MAX[OW-1:0]) || (out_q.turn_rate == T_MIN[OW-1:0])))
    else $error("saturated flag without a clipped result");

endmodule
